[sv/dvfs_pkg.sv]
package dvfs_pkg;

   // field widths
   localparam int DOMAIN_W  = 3;
   localparam int DIV_W     = 5;
   localparam int READING_W = 16;
   localparam int KIND_W    = 3;
   localparam int TILE_W    = 5;
   localparam int CODE_W    = 18;
   localparam int VID_W     = 17;
   localparam int LEVEL_W   = 3;
   localparam int TENTHS_W  = 4;
   localparam int GCLK_W    = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 12;

   // default sizes
   localparam int DEF_NUM_DOMAINS = 6;
   localparam int DEF_NUM_LEVELS  = 7;
   localparam int DOMAIN_TABLE    = 6;
   localparam int LEVEL_TABLE     = 7;
   localparam int MAX_DIVIDER     = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIV = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GCLK    = 2'd2;

   // register reset values
   localparam logic [DIV_W-1:0]  MIN_DIV_RST = 5'd2;
   localparam logic [DIV_W-1:0]  MAX_DIV_RST = 5'd16;
   localparam logic [GCLK_W-1:0] GCLK_RST    = 12'd1600;
   localparam logic [DIV_W-1:0]  CUR_DIV_RST = 5'd3;
   localparam logic [LEVEL_W-1:0] CUR_LVL_RST = 3'd4;

   // request codes
   localparam logic REQ_SET    = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_TILE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_VID    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DONE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REJECT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BUSY   = 3'd4;

   // sensor scale: one count is 251770 units of 1e-10 volt, a tenth of a volt is 1e9
   localparam logic [63:0] SENSOR_LSB  = 64'd251770;
   localparam logic [63:0] TENTH_UNIT  = 64'd1000000000;
   localparam logic [63:0] HALF_UNIT   = 64'd500000000;

   // smallest count whose rounded tenths reach t
   localparam logic [63:0] THR_09 = (64'd9 * TENTH_UNIT - HALF_UNIT + SENSOR_LSB - 64'd1)
                                    / SENSOR_LSB;
   localparam logic [63:0] THR_10 = (64'd10 * TENTH_UNIT - HALF_UNIT + SENSOR_LSB - 64'd1)
                                    / SENSOR_LSB;
   localparam logic [63:0] THR_11 = (64'd11 * TENTH_UNIT - HALF_UNIT + SENSOR_LSB - 64'd1)
                                    / SENSOR_LSB;
   localparam logic [63:0] THR_12 = (64'd12 * TENTH_UNIT - HALF_UNIT + SENSOR_LSB - 64'd1)
                                    / SENSOR_LSB;
   localparam logic [63:0] THR_13 = (64'd13 * TENTH_UNIT - HALF_UNIT + SENSOR_LSB - 64'd1)
                                    / SENSOR_LSB;
   localparam logic [63:0] THR_14 = (64'd14 * TENTH_UNIT - HALF_UNIT + SENSOR_LSB - 64'd1)
                                    / SENSOR_LSB;

   typedef struct packed {
      logic                 req_type;
      logic [DOMAIN_W-1:0]  domain;
      logic [DIV_W-1:0]     divider;
      logic [READING_W-1:0] reading;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [TILE_W-1:0]  tile;
      logic [CODE_W-1:0]  divider_code;
      logic [VID_W-1:0]   vid_word;
      logic [DIV_W-1:0]   new_divider;
      logic [LEVEL_W-1:0] new_level;
      logic               last;
   } rsp_item_type;

   // count threshold for a tenths value, out-of-table values never match
   function automatic logic [READING_W:0] tenths_thr(input logic [TENTHS_W-1:0] t);
      logic [READING_W:0] thr;
      unique case (t)
         4'd9:    thr = THR_09[READING_W:0];
         4'd10:   thr = THR_10[READING_W:0];
         4'd11:   thr = THR_11[READING_W:0];
         4'd12:   thr = THR_12[READING_W:0];
         4'd13:   thr = THR_13[READING_W:0];
         4'd14:   thr = THR_14[READING_W:0];
         default: thr = '1;
      endcase
      return thr;
   endfunction

   // level tables, the unused index wraps to level 0
   function automatic logic [TENTHS_W-1:0] lvl_tenths(input logic [LEVEL_W-1:0] l);
      logic [TENTHS_W-1:0] v;
      unique case (l)
         3'd3:    v = 4'd10;
         3'd4:    v = 4'd11;
         3'd5:    v = 4'd12;
         3'd6:    v = 4'd13;
         default: v = 4'd9;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] lvl_code(input logic [LEVEL_W-1:0] l);
      logic [7:0] v;
      unique case (l)
         3'd3:    v = 8'hA0;
         3'd4:    v = 8'hB0;
         3'd5:    v = 8'hC0;
         3'd6:    v = 8'hD0;
         default: v = 8'h90;
      endcase
      return v;
   endfunction

   function automatic logic [GCLK_W-1:0] lvl_cap(input logic [LEVEL_W-1:0] l);
      logic [GCLK_W-1:0] v;
      unique case (l)
         3'd1:    v = 12'd598;
         3'd2:    v = 12'd644;
         3'd3:    v = 12'd748;
         3'd4:    v = 12'd875;
         3'd5:    v = 12'd1024;
         3'd6:    v = 12'd1198;
         default: v = 12'd460;
      endcase
      return v;
   endfunction

   // frequency change code, steps of 0x3801 from 0x38e0 at divider 1
   function automatic logic [CODE_W-1:0] div_code(input logic [DIV_W-1:0] d);
      logic [CODE_W-1:0] v;
      if (d == '0 || d > DIV_W'(MAX_DIVIDER)) begin
         v = '0;
      end else begin
         v = CODE_W'(d) * 18'h03801 + 18'h000DF;
      end
      return v;
   endfunction

   // four tiles of a domain
   function automatic logic [TILE_W-1:0] dom_tile(input logic [DOMAIN_W-1:0] dom,
                                                  input logic [1:0] idx);
      logic [TILE_W-1:0] base;
      logic [TILE_W-1:0] ofs;
      unique case (dom)
         3'd1:    base = 5'd2;
         3'd2:    base = 5'd4;
         3'd3:    base = 5'd12;
         3'd4:    base = 5'd14;
         3'd5:    base = 5'd16;
         default: base = 5'd0;
      endcase
      unique case (idx)
         2'd0: ofs = 5'd0;
         2'd1: ofs = 5'd1;
         2'd2: ofs = 5'd6;
         2'd3: ofs = 5'd7;
      endcase
      return base + ofs;
   endfunction

   function automatic logic [2:0] phys_dom(input logic [DOMAIN_W-1:0] dom);
      logic [2:0] v;
      unique case (dom)
         3'd0:    v = 3'd4;
         3'd1:    v = 3'd5;
         3'd2:    v = 3'd7;
         3'd3:    v = 3'd0;
         3'd4:    v = 3'd1;
         3'd5:    v = 3'd3;
         default: v = 3'd0;
      endcase
      return v;
   endfunction

endpackage

[sv/dvfs_domain_sequencer.sv]
// set request: taken while idle, then the shared restoring divider (one quotient bit
//   a cycle) and a level search, then one result a cycle unless the
//   output stalls: up to 4 tile writes, 3 regulator writes, 4 tile writes, done
// voltage sample: decided in the cycle it is taken, then a finish step if reached
// only one item is in work at a time; a new one is taken once the results are queued
// reset (synchronous): registers to defaults, every domain at divider 3, level 4
module dvfs_domain_sequencer
   import dvfs_pkg::*;
#(
   parameter int NUM_DOMAINS = DEF_NUM_DOMAINS,
   parameter int NUM_LEVELS  = DEF_NUM_LEVELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DOM_IDX_W = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
   localparam int LVL_LIMIT = (NUM_LEVELS < LEVEL_TABLE) ? NUM_LEVELS : LEVEL_TABLE;
   localparam logic [LEVEL_W-1:0] LVL_LAST = LEVEL_W'(LVL_LIMIT - 1);
   localparam logic [3:0] DIV_LAST = 4'(GCLK_W - 1);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_SRCH  = 4'd2;
   localparam logic [3:0] S_TILE  = 4'd3;
   localparam logic [3:0] S_VID   = 4'd4;
   localparam logic [3:0] S_FIN   = 4'd5;
   localparam logic [3:0] S_FTILE = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;
   localparam logic [3:0] S_ONE   = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [GCLK_W-1:0]    quo_ff, quo_in;
   logic [DOMAIN_W-1:0]  dom_ff, dom_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic [TENTHS_W-1:0]  old_ff, old_in;
   logic                 waiting_ff, waiting_in;
   logic                 imm_ff, imm_in;
   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_ff, rsp_in;

   logic [DIV_W-1:0]     min_div_ff, max_div_ff;
   logic [GCLK_W-1:0]    gclk_ff;

   logic [DIV_W-1:0]     cur_div_ff [NUM_DOMAINS];
   logic [LEVEL_W-1:0]   cur_lvl_ff [NUM_DOMAINS];
   logic                 cur_div_we, cur_lvl_we;
   logic [DOM_IDX_W-1:0] dom_idx;
   logic [DIV_W-1:0]     cur_div_rd;
   logic [LEVEL_W-1:0]   cur_lvl_rd;

   logic                 req_fire;
   logic                 emit_valid, emit_go;
   logic [DIV_W-1:0]     clamped;
   logic                 set_ok;
   logic [TENTHS_W-1:0]  target;
   logic [READING_W:0]   count_x;
   logic                 reached;
   logic [DIV_W:0]       rem_sh;
   logic                 rem_ge;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // domain state read at the working domain only
   assign dom_idx    = dom_ff[DOM_IDX_W-1:0];
   assign cur_div_rd = cur_div_ff[dom_idx];
   assign cur_lvl_rd = cur_lvl_ff[dom_idx];

   // clamp, upper limit first
   always_comb begin
      if (req_data.divider > max_div_ff) begin
         clamped = max_div_ff;
      end else if (req_data.divider < min_div_ff) begin
         clamped = min_div_ff;
      end else begin
         clamped = req_data.divider;
      end
   end

   assign set_ok = (DOMAIN_W'(NUM_DOMAINS) > req_data.domain || NUM_DOMAINS >= 8)
                   && (req_data.domain < DOMAIN_W'(DOMAIN_TABLE))
                   && (clamped != '0) && (clamped <= DIV_W'(MAX_DIVIDER));

   // sample against target, tenths compared as count thresholds
   assign target  = lvl_tenths(lvl_ff);
   assign count_x = {1'b0, req_data.reading};
   always_comb begin
      priority if (target > old_ff) begin
         reached = (count_x >= tenths_thr(target));
      end else if (target < old_ff) begin
         reached = !(count_x >= tenths_thr(target + 4'd1));
      end else begin
         reached = 1'b1;
      end
   end

   // shared divider step: one quotient bit a cycle
   assign rem_sh = {rem_ff, quo_ff[GCLK_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, div_ff});

   assign emit_go = emit_valid && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dom_in     = dom_ff;
      div_in     = div_ff;
      lvl_in     = lvl_ff;
      old_in     = old_ff;
      waiting_in = waiting_ff;
      imm_in     = imm_ff;
      busy_in    = busy_ff;
      cur_div_we = 1'b0;
      cur_lvl_we = 1'b0;
      emit_valid = 1'b0;
      rsp_in     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.req_type == REQ_SAMPLE) begin
                  if (waiting_ff && reached) begin
                     state_in = S_FIN;
                  end
               end else if (waiting_ff) begin
                  busy_in  = 1'b1;
                  state_in = S_ONE;
               end else begin
                  busy_in = 1'b0;
                  dom_in  = req_data.domain;
                  div_in  = clamped;
                  lvl_in  = '0;
                  if (set_ok) begin
                     quo_in   = gclk_ff;
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end else begin
                     state_in = S_ONE;
                  end
               end
            end
         end
         S_DIV: begin
            rem_in = rem_ge ? DIV_W'(rem_sh - {1'b0, div_ff}) : DIV_W'(rem_sh);
            quo_in = {quo_ff[GCLK_W-2:0], rem_ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (lvl_cap(lvl_ff) >= quo_ff) begin
               old_in     = lvl_tenths(cur_lvl_rd);
               imm_in     = (lvl_tenths(lvl_ff) == lvl_tenths(cur_lvl_rd));
               waiting_in = 1'b1;
               cnt_in     = '0;
               if (div_ff >= cur_div_rd) begin
                  cur_div_we = 1'b1;
                  state_in   = S_TILE;
               end else begin
                  state_in = S_VID;
               end
            end else if (lvl_ff == LVL_LAST) begin
               lvl_in   = '0;
               state_in = S_ONE;
            end else begin
               lvl_in = lvl_ff + 3'd1;
            end
         end
         S_TILE, S_FTILE: begin
            emit_valid          = 1'b1;
            rsp_in.kind         = KIND_TILE;
            rsp_in.tile         = dom_tile(dom_ff, cnt_ff[1:0]);
            rsp_in.divider_code = div_code(div_ff);
            rsp_in.new_divider  = div_ff;
            rsp_in.new_level    = lvl_ff;
            if (emit_go) begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd3) begin
                  cnt_in   = '0;
                  state_in = (state_ff == S_TILE) ? S_VID : S_DONE;
               end
            end
         end
         S_VID: begin
            emit_valid         = 1'b1;
            rsp_in.kind        = KIND_VID;
            rsp_in.vid_word    = {1'b1, 5'd0, phys_dom(dom_ff), lvl_code(lvl_ff)};
            rsp_in.new_divider = div_ff;
            rsp_in.new_level   = lvl_ff;
            rsp_in.last        = (cnt_ff == 4'd2) && !imm_ff;
            if (emit_go) begin
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd2) begin
                  cnt_in   = '0;
                  state_in = imm_ff ? S_FIN : S_IDLE;
               end
            end
         end
         S_FIN: begin
            cur_lvl_we = 1'b1;
            waiting_in = 1'b0;
            cnt_in     = '0;
            if (div_ff < cur_div_rd) begin
               cur_div_we = 1'b1;
               state_in   = S_FTILE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            emit_valid         = 1'b1;
            rsp_in.kind        = KIND_DONE;
            rsp_in.new_divider = div_ff;
            rsp_in.new_level   = lvl_ff;
            rsp_in.last        = 1'b1;
            if (emit_go) begin
               state_in = S_IDLE;
            end
         end
         S_ONE: begin
            emit_valid         = 1'b1;
            rsp_in.kind        = busy_ff ? KIND_BUSY : KIND_REJECT;
            rsp_in.new_divider = busy_ff ? '0 : div_ff;
            rsp_in.last        = 1'b1;
            if (emit_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: loads on a new result, empties on a transfer
   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dom_ff       <= '0;
         div_ff       <= '0;
         lvl_ff       <= '0;
         old_ff       <= '0;
         waiting_ff   <= 1'b0;
         imm_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dom_ff       <= dom_in;
         div_ff       <= div_in;
         lvl_ff       <= lvl_in;
         old_ff       <= old_in;
         waiting_ff   <= waiting_in;
         imm_ff       <= imm_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (emit_go) begin
         rsp_ff <= rsp_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_div_ff <= MIN_DIV_RST;
         max_div_ff <= MAX_DIV_RST;
         gclk_ff    <= GCLK_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_DIV: min_div_ff <= csr_wdata[DIV_W-1:0];
            CSR_MAX_DIV: max_div_ff <= csr_wdata[DIV_W-1:0];
            CSR_GCLK:    gclk_ff    <= csr_wdata[GCLK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // per-domain divider and level
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DOMAINS; i++) begin
            cur_div_ff[i] <= CUR_DIV_RST;
            cur_lvl_ff[i] <= CUR_LVL_RST;
         end
      end else begin
         if (cur_div_we) begin
            cur_div_ff[dom_idx] <= div_ff;
         end
         if (cur_lvl_we) begin
            cur_lvl_ff[dom_idx] <= lvl_ff;
         end
      end
   end

   // a set request during a voltage wait answers busy
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.req_type == REQ_SET && waiting_ff)
      |=> (state_ff == S_ONE && busy_ff))
      else $error("set request while waiting did not turn busy");

   // the wait ends only through the finish step
   assert property (@(posedge clock) disable iff (reset)
      ($fell(waiting_ff) && !$past(reset)) |-> ($past(state_ff) == S_FIN))
      else $error("voltage wait ended outside finish");

   // tile writes only carry a divider that has a code
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TILE || state_ff == S_FTILE)
      |-> (div_ff != '0 && div_ff <= DIV_W'(MAX_DIVIDER)))
      else $error("tile write with divider outside code table");

   // the final result of an item leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      (emit_go && rsp_in.last) |=> (state_ff == S_IDLE))
      else $error("last result not followed by idle");

   // regulator writes happen only with a wait armed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VID) |-> waiting_ff)
      else $error("regulator write without pending wait");

endmodule
